// File: rtl/hsc_pkg.sv
// Package for the Hamming single-error-correcting codec.
// Holds shared widths, opcode and status codes, the geometry struct and
// elaboration-time position helpers. No dependencies.
`default_nettype none

package hsc_pkg;

	localparam int MAX_DATA_BITS_DEF = 57;
	localparam int CFG_W             = 6;
	localparam int SYN_W             = 6;
	localparam int STAT_W            = 2;

	localparam logic [CFG_W-1:0] DATA_LEN_RST = 6'd4;

	localparam logic OP_ENCODE  = 1'b0;
	localparam logic OP_CORRECT = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_CLEAN     = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_CORRECTED = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BEYOND    = 2'd2;

	// Effective code geometry derived from the data length register.
	typedef struct packed {
		logic [CFG_W-1:0] len;
		logic [SYN_W-1:0] n;
	} geom_t;

	function automatic bit is_pow2(input int p);
		return (p & (p - 1)) == 0;
	endfunction

	// Least r with 2^r >= len + r + 1.
	function automatic int parity_count(input int len);
		int r;
		r = 0;
		while (r < 7 && (1 << r) < len + r + 1) r++;
		return r;
	endfunction

	// Data index held at codeword position p (p not a power of two).
	function automatic int data_index_of(input int p);
		int cnt;
		cnt = 0;
		for (int i = 0; i < 7; i++) begin
			if ((1 << i) <= p) cnt++;
		end
		return p - 1 - cnt;
	endfunction

	// Codeword position that holds data index j.
	function automatic int data_pos_of(input int j);
		int p;
		int seen;
		p = 0;
		seen = -1;
		while (seen < j) begin
			p++;
			if (!is_pow2(p)) seen++;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// File: rtl/hsc_cfg.sv
// Data length register and code geometry for the Hamming codec.
// Depends on hsc_pkg (widths, reset value, geom_t).
`default_nettype none

module hsc_cfg #(
	parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [hsc_pkg::CFG_W-1:0] cfg_wr_data,
	output hsc_pkg::geom_t                geom
);

	localparam logic [hsc_pkg::CFG_W-1:0] LEN_MAX = hsc_pkg::CFG_W'(MAX_DATA_BITS);

	logic [hsc_pkg::CFG_W-1:0] data_length_q;
	logic [hsc_pkg::CFG_W-1:0] len;
	logic [6:0]                short_v;
	logic [2:0]                r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= hsc_pkg::DATA_LEN_RST;
		end else if (cfg_wr_en) begin
			data_length_q <= cfg_wr_data;
		end
	end

	// Clamp the raw value into 1..MAX_DATA_BITS.
	always_comb begin
		priority if (data_length_q == '0) begin
			len = hsc_pkg::CFG_W'(1);
		end else if (data_length_q > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = data_length_q;
		end
	end

	// Count how many powers of two fall short of len + i + 1; the test is
	// monotone in i, so the count is the parity count.
	for (genvar i = 0; i < 7; i++) begin : g_short
		assign short_v[i] = (7'(1 << i)) < (7'(len) + 7'(i + 1));
	end

	assign r        = 3'($countones(short_v));
	assign geom.len = len;
	assign geom.n   = hsc_pkg::SYN_W'(len + {3'b000, r});

endmodule

`default_nettype wire

// File: rtl/hsc_datapath.sv
// Encode and check/correct logic of the Hamming codec, one word per pass.
// Depends on hsc_pkg (codes, geom_t, position helpers).
`default_nettype none

module hsc_datapath #(
	parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF,
	parameter int CW_W          = MAX_DATA_BITS + hsc_pkg::parity_count(MAX_DATA_BITS)
) (
	input  wire logic                       opcode,
	input  wire logic [MAX_DATA_BITS-1:0]   data_in,
	input  wire logic [CW_W-1:0]            codeword_in,
	input  wire hsc_pkg::geom_t             geom,
	output logic      [CW_W-1:0]            codeword_out,
	output logic      [MAX_DATA_BITS-1:0]   data_out,
	output logic      [hsc_pkg::SYN_W-1:0]  syndrome,
	output logic      [hsc_pkg::STAT_W-1:0] status
);

	logic [CW_W-1:0]          nmask;
	logic [CW_W-1:0]          placed;
	logic [CW_W-1:0]          work;
	logic [CW_W-1:0]          parity_set;
	logic [CW_W-1:0]          flip;
	logic [MAX_DATA_BITS-1:0] data_m;
	logic [hsc_pkg::SYN_W-1:0][CW_W-1:0] syn_sel;
	logic [hsc_pkg::SYN_W-1:0] syn;
	logic                     in_range;
	logic                     fix_en;

	for (genvar j = 0; j < MAX_DATA_BITS; j++) begin : g_dmask
		assign data_m[j] = data_in[j] & (hsc_pkg::CFG_W'(j) < geom.len);
	end

	for (genvar k = 0; k < CW_W; k++) begin : g_pos
		assign nmask[k] = hsc_pkg::SYN_W'(k + 1) <= geom.n;
		if (hsc_pkg::is_pow2(k + 1)) begin : g_par
			assign placed[k]     = 1'b0;
			assign parity_set[k] = syn[$clog2(k + 1)];
		end else begin : g_dat
			assign placed[k]     = data_m[hsc_pkg::data_index_of(k + 1)];
			assign parity_set[k] = 1'b0;
		end
		assign flip[k] = fix_en & (syn == hsc_pkg::SYN_W'(k + 1));
	end

	assign work = (opcode == hsc_pkg::OP_CORRECT) ? (codeword_in & nmask) : placed;

	// Syndrome bit i is the parity of all positions whose index has bit i set.
	for (genvar i = 0; i < hsc_pkg::SYN_W; i++) begin : g_syn
		for (genvar k = 0; k < CW_W; k++) begin : g_sel
			if ((((k + 1) >> i) & 1) != 0) begin : g_on
				assign syn_sel[i][k] = work[k];
			end else begin : g_off
				assign syn_sel[i][k] = 1'b0;
			end
		end
		assign syn[i] = ^syn_sel[i];
	end

	assign in_range = syn <= geom.n;
	assign fix_en   = (opcode == hsc_pkg::OP_CORRECT) && (syn != '0) && in_range;

	always_comb begin
		unique case (opcode)
			hsc_pkg::OP_ENCODE: begin
				codeword_out = placed | parity_set;
				syndrome     = '0;
				status       = hsc_pkg::STATUS_CLEAN;
			end
			default: begin
				codeword_out = work ^ flip;
				syndrome     = syn;
				priority if (syn == '0) begin
					status = hsc_pkg::STATUS_CLEAN;
				end else if (in_range) begin
					status = hsc_pkg::STATUS_CORRECTED;
				end else begin
					status = hsc_pkg::STATUS_BEYOND;
				end
			end
		endcase
	end

	for (genvar j = 0; j < MAX_DATA_BITS; j++) begin : g_ext
		assign data_out[j] = codeword_out[hsc_pkg::data_pos_of(j) - 1];
	end

endmodule

`default_nettype wire

// File: rtl/hamming_sec_codec.sv
// Top level of the Hamming single-error-correcting codec.
// Depends on hsc_pkg, hsc_cfg and hsc_datapath.
//
// Usage:
//  - Input channel: drive opcode, data_in and codeword_in with start high; a
//    word is taken at every rising edge where start is high and busy is low.
//    busy never rises, so one word can be taken in every cycle.
//  - opcode selects encode (build the codeword from data_in) or correct
//    (compute the syndrome of codeword_in and flip the erroneous bit).
//  - Output channel: done is high for exactly one cycle with codeword_out,
//    data_out, syndrome and status valid in that cycle. A word taken at a
//    rising edge is held in the input register, passes the encode/correct
//    logic and lands in the result register, whose outputs show it.
//  - Throughput is one word per cycle; the input and result registers bound
//    the single combinational pass through the syndrome XOR trees.
//  - The receiver cannot stall; every result must be taken when done is high.
//  - Configuration: cfg_wr_en writes cfg_wr_data to the data length register
//    (zero is used as one, values above MAX_DATA_BITS as MAX_DATA_BITS).
//    Write it only while no word is in flight.
//  - Reset clears the pipeline valid bits and sets the data length to four.
`default_nettype none

module hamming_sec_codec #(
	parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF,
	localparam int CW_W         = MAX_DATA_BITS + hsc_pkg::parity_count(MAX_DATA_BITS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [hsc_pkg::CFG_W-1:0]  cfg_wr_data,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       opcode,
	input  wire logic [MAX_DATA_BITS-1:0]   data_in,
	input  wire logic [CW_W-1:0]            codeword_in,
	output logic                            done,
	output logic      [CW_W-1:0]            codeword_out,
	output logic      [MAX_DATA_BITS-1:0]   data_out,
	output logic      [hsc_pkg::SYN_W-1:0]  syndrome,
	output logic      [hsc_pkg::STAT_W-1:0] status
);

	hsc_pkg::geom_t geom;

	// Input register stage.
	logic                     valid_s1;
	logic                     opcode_s1;
	logic [MAX_DATA_BITS-1:0] data_s1;
	logic [CW_W-1:0]          cw_s1;

	// Combinational results.
	logic [CW_W-1:0]            cw_c;
	logic [MAX_DATA_BITS-1:0]   data_c;
	logic [hsc_pkg::SYN_W-1:0]  syn_c;
	logic [hsc_pkg::STAT_W-1:0] status_c;

	// Result register stage.
	logic                       valid_s2;
	logic [CW_W-1:0]            cw_s2;
	logic [MAX_DATA_BITS-1:0]   data_s2;
	logic [hsc_pkg::SYN_W-1:0]  syn_s2;
	logic [hsc_pkg::STAT_W-1:0] status_s2;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	hsc_cfg #(
		.MAX_DATA_BITS (MAX_DATA_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.geom        (geom)
	);

	// Advance the valid bits every cycle; the receiver never holds off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Capture the word only when it is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			data_s1   <= data_in;
			cw_s1     <= codeword_in;
		end
	end

	hsc_datapath #(
		.MAX_DATA_BITS (MAX_DATA_BITS),
		.CW_W          (CW_W)
	) u_datapath (
		.opcode       (opcode_s1),
		.data_in      (data_s1),
		.codeword_in  (cw_s1),
		.geom         (geom),
		.codeword_out (cw_c),
		.data_out     (data_c),
		.syndrome     (syn_c),
		.status       (status_c)
	);

	// Load the result register behind a valid input stage.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cw_s2     <= cw_c;
			data_s2   <= data_c;
			syn_s2    <= syn_c;
			status_s2 <= status_c;
		end
	end

	assign done         = valid_s2;
	assign codeword_out = cw_s2;
	assign data_out     = data_s2;
	assign syndrome     = syn_s2;
	assign status       = status_s2;

	// Every taken word yields exactly one result strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result strobe missing two cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> ##2 !done)
		else $error("result strobe without a taken word");

	a_encode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == hsc_pkg::OP_ENCODE) |-> ##2
		(syndrome == '0 && status == hsc_pkg::STATUS_CLEAN))
		else $error("encode result reports an error");

	a_status_syn: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == hsc_pkg::STATUS_CLEAN) == (syndrome == '0)))
		else $error("status disagrees with syndrome");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == hsc_pkg::STATUS_CLEAN || status == hsc_pkg::STATUS_CORRECTED
			|| status == hsc_pkg::STATUS_BEYOND))
		else $error("status code out of range");

endmodule

`default_nettype wire

// File: tb/tb_hamming_sec_codec.sv
// Self-checking testbench for the Hamming single-error-correcting codec.
// Depends on hsc_pkg and the hamming_sec_codec RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_hamming_sec_codec;

	localparam int DW           = hsc_pkg::MAX_DATA_BITS_DEF;
	localparam int CW_W         = 63;
	localparam int SYN_W        = hsc_pkg::SYN_W;
	localparam int STAT_W       = hsc_pkg::STAT_W;
	localparam int LIMIT_CYCLES = 100000;
	localparam int WORDS_PER_LEN = 43;

	// One expected result word, laid out like the result ports.
	typedef struct packed {
		logic [CW_W-1:0]   cw;
		logic [DW-1:0]     data;
		logic [SYN_W-1:0]  syn;
		logic [STAT_W-1:0] st;
	} codec_result_t;

	// Scoreboard: keeps its own copy of the data length register, works out
	// the result for every word taken and checks results in order.
	class sec_word_checker;
		logic [hsc_pkg::CFG_W-1:0] length_reg;
		codec_result_t owed_words[$];
		int errors;

		function new();
			length_reg = hsc_pkg::DATA_LEN_RST;
			errors = 0;
		endfunction

		function void set_length(logic [hsc_pkg::CFG_W-1:0] v);
			length_reg = v;
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		// Clamp the raw register and derive parity count and code length.
		function void geometry(output int len, output int r, output int n);
			len = length_reg;
			if (len < 1) len = 1;
			if (len > DW) len = DW;
			r = 0;
			while ((1 << r) < len + r + 1) r++;
			n = len + r;
		endfunction

		// XOR of the indexes of all set positions 1..n.
		function logic [SYN_W-1:0] position_xor(logic [CW_W-1:0] w, int n);
			logic [SYN_W-1:0] s;
			s = '0;
			for (int p = 1; p <= n; p++)
				if (w[p-1]) s ^= SYN_W'(p);
			return s;
		endfunction

		function logic [CW_W-1:0] encode_data(logic [DW-1:0] d);
			int len, r, n, j;
			logic [CW_W-1:0] w;
			logic [SYN_W-1:0] s;
			geometry(len, r, n);
			w = '0;
			j = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					w[p-1] = d[j];
					j++;
				end
			end
			// set each parity bit so the whole word XORs to a zero syndrome
			s = position_xor(w, n);
			for (int i = 0; i < r; i++)
				if (s[i]) w[(1 << i) - 1] = 1'b1;
			return w;
		endfunction

		function logic [DW-1:0] pull_data(logic [CW_W-1:0] w, int n);
			logic [DW-1:0] d;
			int j;
			d = '0;
			j = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					d[j] = w[p-1];
					j++;
				end
			end
			return d;
		endfunction

		function codec_result_t predict_word(logic op, logic [DW-1:0] d,
				logic [CW_W-1:0] cwi);
			codec_result_t e;
			int len, r, n;
			logic [CW_W-1:0] w;
			geometry(len, r, n);
			w = cwi;
			for (int q = n; q < CW_W; q++) w[q] = 1'b0;
			if (op == hsc_pkg::OP_ENCODE) begin
				e.cw  = encode_data(d);
				e.syn = '0;
				e.st  = hsc_pkg::STATUS_CLEAN;
			end else begin
				e.syn = position_xor(w, n);
				if (e.syn == 0) begin
					e.st = hsc_pkg::STATUS_CLEAN;
				end else if (int'(e.syn) <= n) begin
					w[e.syn-1] = ~w[e.syn-1];
					e.st = hsc_pkg::STATUS_CORRECTED;
				end else begin
					// pointer past the code: pass the word through untouched
					e.st = hsc_pkg::STATUS_BEYOND;
				end
				e.cw = w;
			end
			e.data = pull_data(e.cw, n);
			return e;
		endfunction

		function void note_word(logic op, logic [DW-1:0] d, logic [CW_W-1:0] cwi);
			owed_words.push_back(predict_word(op, d, cwi));
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
			errors++;
		endtask

		task check_word(logic [CW_W-1:0] cw, logic [DW-1:0] d,
				logic [SYN_W-1:0] syn, logic [STAT_W-1:0] st);
			codec_result_t want;
			if (owed_words.size() == 0) begin
				report_mismatch("unowed result", 64'(cw), 64'(0));
				return;
			end
			want = owed_words.pop_front();
			if (cw !== want.cw)   report_mismatch("codeword_out", 64'(cw), 64'(want.cw));
			if (d !== want.data)  report_mismatch("data_out", 64'(d), 64'(want.data));
			if (syn !== want.syn) report_mismatch("syndrome", 64'(syn), 64'(want.syn));
			if (st !== want.st)   report_mismatch("status", 64'(st), 64'(want.st));
		endtask
	endclass

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wr_en   = 1'b0;
	logic [hsc_pkg::CFG_W-1:0] cfg_wr_data = '0;
	logic                      start       = 1'b0;
	logic                      opcode      = hsc_pkg::OP_ENCODE;
	logic [DW-1:0]             data_in     = '0;
	logic [CW_W-1:0]           codeword_in = '0;
	logic                      busy;
	logic                      done;
	logic [CW_W-1:0]           codeword_out;
	logic [DW-1:0]             data_out;
	logic [SYN_W-1:0]          syndrome;
	logic [STAT_W-1:0]         status;

	logic        busy_seen   = 1'b0;
	bit          gaps_on     = 1'b1;
	int unsigned cycle_count = 0;
	sec_word_checker ledger;

	hamming_sec_codec u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.data_in      (data_in),
		.codeword_in  (codeword_in),
		.done         (done),
		.codeword_out (codeword_out),
		.data_out     (data_out),
		.syndrome     (syndrome),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample busy mid-cycle so the driver knows, at the next rising edge,
	// whether the word it is holding was taken there.
	always @(negedge clk) begin
		busy_seen <= busy;
	end

	// Monitor: check results, note taken words and mirror register writes,
	// all on values from before the edge.
	always @(posedge clk) begin
		if (done) ledger.check_word(codeword_out, data_out, syndrome, status);
		if (start && !busy) ledger.note_word(opcode, data_in, codeword_in);
		if (cfg_wr_en) ledger.set_length(cfg_wr_data);
	end

	// Watchdog: end the run once the cycle count reaches LIMIT_CYCLES.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_hamming_sec_codec: done, errors");
			$finish;
		end
	end

	// Drop start for a random burst now and then, while gaps are enabled.
	task automatic idle_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Present one word and hold it until the block takes it.
	task automatic send_word(input logic op, input logic [DW-1:0] d,
			input logic [CW_W-1:0] w);
		idle_gap();
		start       <= 1'b1;
		opcode      <= op;
		data_in     <= d;
		codeword_in <= w;
		do @(posedge clk); while (busy_seen);
	endtask

	// Lower start and wait until every owed result has come back.
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (ledger.pending() != 0) @(negedge clk);
	endtask

	task automatic write_length(input logic [hsc_pkg::CFG_W-1:0] v);
		drain();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly well-formed traffic: encodes, clean codewords and codewords with
	// one flipped bit; the rest carries junk above the code or is pure noise.
	task automatic send_random_word();
		int len, r, n, pick, pos;
		logic [DW-1:0] d;
		logic [CW_W-1:0] w, noise;
		ledger.geometry(len, r, n);
		d     = DW'({$urandom, $urandom});
		noise = CW_W'({$urandom, $urandom});
		w     = ledger.encode_data(d);
		pick  = $urandom_range(0, 9);
		if (pick <= 2) begin
			send_word(hsc_pkg::OP_ENCODE, d, noise);
		end else if (pick <= 4) begin
			send_word(hsc_pkg::OP_CORRECT, d, w);
		end else if (pick <= 7) begin
			pos = $urandom_range(1, n);
			w[pos-1] = ~w[pos-1];
			send_word(hsc_pkg::OP_CORRECT, d, w);
		end else if (pick == 8) begin
			pos = $urandom_range(1, CW_W);
			w[pos-1] = ~w[pos-1];
			for (int q = n; q < CW_W; q++) w[q] = noise[q];
			send_word(hsc_pkg::OP_CORRECT, d, w);
		end else begin
			send_word(hsc_pkg::OP_CORRECT, d, noise);
		end
	endtask

	initial begin : main
		logic [CW_W-1:0] good;
		int lengths[10];

		ledger = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset length of four (seven-bit code).
		send_word(hsc_pkg::OP_ENCODE, '0, '0);
		send_word(hsc_pkg::OP_ENCODE, '1, '1);
		// data bits above the length must be ignored
		send_word(hsc_pkg::OP_ENCODE, {53'h15_5555_5555_5555, 4'b1010}, '0);
		good = ledger.encode_data(DW'(4'b1011));
		send_word(hsc_pkg::OP_CORRECT, '0, good);
		// a single error at every position of the code
		for (int p = 1; p <= 7; p++) begin
			send_word(hsc_pkg::OP_CORRECT, '1, good ^ (CW_W'(1) << (p - 1)));
		end
		// junk above the code is masked off before the syndrome
		send_word(hsc_pkg::OP_CORRECT, '0, '1);
		send_word(hsc_pkg::OP_CORRECT, '1, '0);

		// Length two gives a five-bit code, so syndromes six and seven
		// point past its end.
		write_length(6'd2);
		send_word(hsc_pkg::OP_ENCODE, DW'(2'b11), '0);
		send_word(hsc_pkg::OP_CORRECT, '0, CW_W'(6'b001010));
		send_word(hsc_pkg::OP_CORRECT, '0, CW_W'(6'b001100));
		send_word(hsc_pkg::OP_CORRECT, '0, CW_W'(6'b011110));

		// Random phases over several lengths: full size, smallest, zero and the
		// all-ones value that clamp, two, just past the limit, 11, 26 and two random.
		lengths = '{57, 1, 0, 63, 2, 58, 11, 26, 0, 0};
		lengths[8] = $urandom_range(0, 63);
		lengths[9] = $urandom_range(0, 63);
		foreach (lengths[k]) begin
			write_length(hsc_pkg::CFG_W'(lengths[k]));
			// run the last phase back to back
			if (k == 9) gaps_on = 1'b0;
			repeat (WORDS_PER_LEN) send_random_word();
		end

		drain();
		// let any stray result show up before the verdict
		repeat (4) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("tb_hamming_sec_codec: done, clean");
		end else begin
			$display("tb_hamming_sec_codec: done, errors");
		end
		$finish;
	end

endmodule
